>>> design/nonce_response_checker_assert.svh
// Assertion macros for the nonce response checker design file.
`ifndef NONCE_RESPONSE_CHECKER_ASSERT_SVH
`define NONCE_RESPONSE_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

`define NRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define NRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define NRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define NRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/nrc_pkg.sv
package nrc_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int POS_W = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_FIRST      = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SECOND     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_NONCE_LAST = POS_W'(FRAME_BYTES - 4);
    localparam logic [POS_W-1:0] POS_CHIP       = POS_W'(FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

    localparam int CRC_W = 5;
    localparam logic [CRC_W-1:0] CRC_INIT = 5'h1f;
    localparam logic [CRC_W-1:0] CRC_POLY_LOW = 5'h05;
    localparam int FLAG_BIT = 7;
    localparam int FLAG_W = 3;
    localparam int TAIL_BITS = 3;

    localparam int ADDR_W = 3;
    localparam logic REG_PREAMBLE_FIRST  = 1'b0;
    localparam logic REG_PREAMBLE_SECOND = 1'b1;
    localparam logic [7:0] PREAMBLE_FIRST_RESET  = 8'h55;
    localparam logic [7:0] PREAMBLE_SECOND_RESET = 8'haa;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_FLAGGED      = 2'd1,
        STATUS_BAD_PREAMBLE = 2'd2,
        STATUS_CRC_MISMATCH = 2'd3
    } status_t;

    // Shifts the top nbits of a byte into the CRC, most significant bit first.
    function automatic logic [CRC_W-1:0] crc5_update(
        input logic [CRC_W-1:0] crc_in,
        input logic [7:0]       data,
        input int unsigned      nbits
    );
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            if (k < nbits)
            begin
                fb = data[7-k] ^ crc[CRC_W-1];
                crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY_LOW : '0);
            end
        end
        return crc;
    endfunction

endpackage

>>> design/nonce_response_checker.sv
// Checks nine-byte response frames arriving one byte per beat. A beat with
// frame_start set begins a new frame and silently drops any partial one.
// Each beat is captured in an input register and processed from there;
// after the ninth byte a single result beat is loaded into the output
// register: ok with nonce, chip address, register index and flag bits,
// flagged, bad preamble or CRC mismatch. The block takes one input beat every
// cycle; it stalls only when a frame's last byte is waiting and the previous
// result is still held in the output register. The two expected preamble
// bytes are set through the register port at addresses 0x0 and 0x4 and must
// only be written while the block is idle.
module nonce_response_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output nrc_pkg::status_t              status,
    output logic [31:0]                   nonce_value,
    output logic [7:0]                    chip_address,
    output logic [7:0]                    register_index,
    output logic [2:0]                    flag_bits,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nrc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import nrc_pkg::*;

    logic [7:0]       pre_first_reg;
    logic [7:0]       pre_second_reg;

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_start_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CRC_W-1:0] crc_reg, crc_next;
    logic             pre_good_reg, pre_good_next;
    logic [31:0]      nonce_reg, nonce_next;
    logic [7:0]       chip_reg, chip_next;
    logic [7:0]       regidx_reg, regidx_next;

    logic             out_valid_reg;
    status_t          status_reg, status_next;
    logic [31:0]      out_nonce_reg, out_nonce_next;
    logic [7:0]       out_chip_reg, out_chip_next;
    logic [7:0]       out_regidx_reg, out_regidx_next;
    logic [FLAG_W-1:0] out_flag_reg, out_flag_next;

    logic             cfg_write;
    logic             accept;
    logic             advance;
    logic             is_last;
    logic [POS_W-1:0] pos_cur;
    logic [CRC_W-1:0] crc_tail;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_first_reg <= PREAMBLE_FIRST_RESET;
            pre_second_reg <= PREAMBLE_SECOND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_PREAMBLE_FIRST:  pre_first_reg <= pwdata[7:0];
                REG_PREAMBLE_SECOND: pre_second_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PREAMBLE_FIRST:  prdata = {24'd0, pre_first_reg};
            REG_PREAMBLE_SECOND: prdata = {24'd0, pre_second_reg};
            default:             prdata = '0;
        endcase
    end

    assign pos_cur = s1_start_reg ? POS_FIRST : pos_reg;
    assign is_last = (pos_cur == POS_LAST);
    assign advance = s1_valid_reg && (!is_last || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_start_reg <= frame_start;
        end
    end

    assign crc_tail = crc5_update(crc_reg, s1_byte_reg, TAIL_BITS);

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        pre_good_next = pre_good_reg;
        nonce_next = nonce_reg;
        chip_next = chip_reg;
        regidx_next = regidx_reg;
        if (advance)
        begin
            priority if (pos_cur == POS_FIRST)
            begin
                pre_good_next = (s1_byte_reg == pre_first_reg);
                crc_next = CRC_INIT;
                pos_next = POS_SECOND;
            end
            else if (pos_cur == POS_SECOND)
            begin
                pre_good_next = pre_good_reg && (s1_byte_reg == pre_second_reg);
                crc_next = CRC_INIT;
                pos_next = pos_cur + POS_W'(1);
            end
            else if (pos_cur < POS_LAST)
            begin
                crc_next = crc5_update(crc_reg, s1_byte_reg, 8);
                if (pos_cur <= POS_NONCE_LAST)
                begin
                    nonce_next = {nonce_reg[23:0], s1_byte_reg};
                end
                else if (pos_cur == POS_CHIP)
                begin
                    chip_next = s1_byte_reg;
                end
                else
                begin
                    regidx_next = s1_byte_reg;
                end
                pos_next = pos_cur + POS_W'(1);
            end
            else
            begin
                crc_next = CRC_INIT;
                pos_next = POS_FIRST;
            end
        end
    end

    always_comb
    begin
        status_next = STATUS_OK;
        out_nonce_next = '0;
        out_chip_next = '0;
        out_regidx_next = '0;
        out_flag_next = '0;
        priority if (!pre_good_reg)
        begin
            status_next = STATUS_BAD_PREAMBLE;
        end
        else if (s1_byte_reg[FLAG_BIT])
        begin
            status_next = STATUS_FLAGGED;
            out_flag_next = s1_byte_reg[7 -: FLAG_W];
        end
        else if (crc_tail != s1_byte_reg[CRC_W-1:0])
        begin
            status_next = STATUS_CRC_MISMATCH;
        end
        else
        begin
            out_nonce_next = nonce_reg;
            out_chip_next = chip_reg;
            out_regidx_next = regidx_reg;
            out_flag_next = s1_byte_reg[7 -: FLAG_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
            crc_reg <= CRC_INIT;
            pre_good_reg <= 1'b1;
            nonce_reg <= '0;
            chip_reg <= '0;
            regidx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            pre_good_reg <= pre_good_next;
            nonce_reg <= nonce_next;
            chip_reg <= chip_next;
            regidx_reg <= regidx_next;
            if (advance && is_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_last)
        begin
            status_reg <= status_next;
            out_nonce_reg <= out_nonce_next;
            out_chip_reg <= out_chip_next;
            out_regidx_reg <= out_regidx_next;
            out_flag_reg <= out_flag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign nonce_value = out_nonce_reg;
    assign chip_address = out_chip_reg;
    assign register_index = out_regidx_reg;
    assign flag_bits = out_flag_reg;

`include "nonce_response_checker_assert.svh"

    `NRC_ASSERT_IMPLIES(a_payload_zero_unless_ok, clk, rst_n, out_valid_reg && status_reg != STATUS_OK, out_nonce_reg == '0 && out_chip_reg == '0 && out_regidx_reg == '0)
    `NRC_ASSERT_IMPLIES(a_flags_zero_on_error, clk, rst_n, out_valid_reg && (status_reg == STATUS_BAD_PREAMBLE || status_reg == STATUS_CRC_MISMATCH), out_flag_reg == '0)
    `NRC_ASSERT_IMPLIES(a_stall_only_on_held_result, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && is_last)
    `NRC_ASSERT_IMPLIES(a_position_in_frame, clk, rst_n, 1'b1, pos_reg < POS_W'(FRAME_BYTES))
    `NRC_ASSERT_NEXT(a_result_after_last_byte, clk, rst_n, advance && is_last, out_valid_reg)

endmodule
